@@ hdl/osc_pkg.sv @@
package osc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int COUNT_BITS  = 24;

  localparam int WIN_DEPTH = MAX_PATTERN - 1;
  localparam int FILL_W    = $clog2(MAX_PATTERN);
  localparam int LEN_W     = 5;
  localparam int PAT_W     = 8 * MAX_PATTERN;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int OCC_W     = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO  = 2'd0,
    CFG_PAT_HI  = 2'd1,
    CFG_PAT_LEN = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } in_req_t;

  typedef struct packed {
    logic             match_end;
    logic [OCC_W-1:0] occurrence_count;
    logic             result_last;
  } out_rsp_t;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  // one request leaving the input register toward the result register
  typedef struct packed {
    logic       adv;
    logic       last;
    logic       hit;
    logic [7:0] text_byte;
  } step_t;

endpackage

@@ hdl/osc_match.sv @@
module osc_match (
  input  logic [7:0]                 text_byte_i,
  input  osc_pkg::win_t              win_i,
  input  logic [osc_pkg::FILL_W-1:0] fill_i,
  input  logic [osc_pkg::CFG_W-1:0]  pat_lo_i,
  input  logic [osc_pkg::CFG_W-1:0]  pat_hi_i,
  input  logic [osc_pkg::LEN_W-1:0]  pat_len_i,
  output logic                       hit_o
);

  logic [osc_pkg::LEN_W-1:0]     eff_len;
  logic [osc_pkg::LEN_W-1:0]     shamt;
  logic [2*osc_pkg::CFG_W-1:0]   pat_full;
  logic [osc_pkg::PAT_W-1:0]     pat_vec;
  logic [osc_pkg::PAT_W-1:0]     aligned;
  logic [osc_pkg::MAX_PATTERN-1:0] lane_ok;
  logic                          fill_ok;

  always_comb begin
    if (pat_len_i == '0) begin
      eff_len = osc_pkg::LEN_W'(1);
    end else if (pat_len_i > osc_pkg::LEN_W'(osc_pkg::MAX_PATTERN)) begin
      eff_len = osc_pkg::LEN_W'(osc_pkg::MAX_PATTERN);
    end else begin
      eff_len = pat_len_i;
    end
  end

  // last pattern byte lands in the top byte lane
  assign shamt    = osc_pkg::LEN_W'(osc_pkg::MAX_PATTERN) - eff_len;
  assign pat_full = {pat_hi_i, pat_lo_i};
  assign pat_vec  = pat_full[osc_pkg::PAT_W-1:0];
  assign aligned  = pat_vec << {shamt, 3'b000};

  // lane 0 is the new byte, lane j>0 is window entry j-1
  always_comb begin
    for (int j = 0; j < osc_pkg::MAX_PATTERN; j++) begin
      logic [7:0] cand;
      if (j == 0) begin
        cand = text_byte_i;
      end else begin
        cand = win_i[j-1];
      end
      lane_ok[j] = (osc_pkg::LEN_W'(j) >= eff_len) ||
                   (cand == aligned[8*(osc_pkg::MAX_PATTERN-1-j) +: 8]);
    end
  end

  assign fill_ok = osc_pkg::LEN_W'(fill_i) >= (eff_len - osc_pkg::LEN_W'(1));
  assign hit_o   = fill_ok & (&lane_ok);

endmodule

@@ hdl/osc_track.sv @@
module osc_track (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  osc_pkg::step_t                 step_i,
  output osc_pkg::win_t                  win_o,
  output logic [osc_pkg::FILL_W-1:0]     fill_o,
  output logic [osc_pkg::COUNT_BITS-1:0] count_upd_o,
  output logic [osc_pkg::COUNT_BITS-1:0] count_o
);

  osc_pkg::win_t                  win_q, win_d;
  logic [osc_pkg::FILL_W-1:0]     fill_q, fill_d;
  logic [osc_pkg::COUNT_BITS-1:0] count_q, count_d;
  logic [osc_pkg::COUNT_BITS-1:0] count_upd;

  // saturating count including the current byte
  assign count_upd = (step_i.hit && (count_q != '1)) ?
                     count_q + osc_pkg::COUNT_BITS'(1) : count_q;

  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    count_d = count_q;
    if (step_i.adv) begin
      if (step_i.last) begin
        win_d   = '0;
        fill_d  = '0;
        count_d = '0;
      end else begin
        for (int k = osc_pkg::WIN_DEPTH - 1; k > 0; k--) begin
          win_d[k] = win_q[k-1];
        end
        win_d[0] = step_i.text_byte;
        if (fill_q != osc_pkg::FILL_W'(osc_pkg::WIN_DEPTH)) begin
          fill_d = fill_q + osc_pkg::FILL_W'(1);
        end
        count_d = count_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      count_q <= '0;
    end else begin
      win_q   <= win_d;
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  assign win_o       = win_q;
  assign fill_o      = fill_q;
  assign count_upd_o = count_upd;
  assign count_o     = count_q;

endmodule

@@ hdl/overlapping_substring_counter.sv @@
// Path: input register, then result register; the window compare is one combinational pass.
// Throughput: one request per cycle while the result register is not full and stalled.
// in_stall_o rises only while the input register holds a request and the result
// register is full and stalled.
// Reset: window, fill and count clear; pattern 0, pattern length 1; both registers empty.
module overlapping_substring_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  osc_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output osc_pkg::out_rsp_t             out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [osc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [osc_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [osc_pkg::CFG_W-1:0]      pat_lo_q, pat_hi_q;
  logic [osc_pkg::LEN_W-1:0]      pat_len_q;

  logic                           s1_valid_q, s1_valid_d;
  osc_pkg::in_req_t               s1_req_q;
  logic                           out_valid_q, out_valid_d;
  osc_pkg::out_rsp_t              out_rsp_q;

  logic                           accept;
  logic                           s1_adv;
  logic                           hit;
  osc_pkg::step_t                 step;
  osc_pkg::win_t                  win;
  logic [osc_pkg::FILL_W-1:0]     fill;
  logic [osc_pkg::COUNT_BITS-1:0] count_upd;
  logic [osc_pkg::COUNT_BITS-1:0] count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= osc_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        osc_pkg::CFG_PAT_LO:  pat_lo_q  <= cfg_data_i;
        osc_pkg::CFG_PAT_HI:  pat_hi_q  <= cfg_data_i;
        osc_pkg::CFG_PAT_LEN: pat_len_q <= cfg_data_i[osc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign accept     = in_valid_i & ~in_stall_o;

  assign s1_valid_d  = accept | (s1_valid_q & ~s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= in_req_i;
    end
    if (s1_adv) begin
      out_rsp_q.match_end        <= hit;
      out_rsp_q.occurrence_count <= osc_pkg::OCC_W'(count_upd);
      out_rsp_q.result_last      <= s1_req_q.text_last;
    end
  end

  osc_match u_match (
    .text_byte_i (s1_req_q.text_byte),
    .win_i       (win),
    .fill_i      (fill),
    .pat_lo_i    (pat_lo_q),
    .pat_hi_i    (pat_hi_q),
    .pat_len_i   (pat_len_q),
    .hit_o       (hit)
  );

  assign step.adv       = s1_adv;
  assign step.last      = s1_req_q.text_last;
  assign step.hit       = hit;
  assign step.text_byte = s1_req_q.text_byte;

  osc_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .win_o       (win),
    .fill_o      (fill),
    .count_upd_o (count_upd),
    .count_o     (count)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_no_adv_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !s1_adv)
    else $error("input register advanced into a stalled result register");

  a_last_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_req_q.text_last) |=> (count == '0 && fill == '0))
    else $error("count or fill not cleared after last byte");

  a_match_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.match_end) |-> (out_rsp_o.occurrence_count != '0))
    else $error("match reported with zero count");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= osc_pkg::FILL_W'(osc_pkg::WIN_DEPTH))
    else $error("window fill beyond window depth");

endmodule

@@ tb/sv/tb_overlapping_substring_counter.sv @@
`timescale 1ns / 1ps

module tb_overlapping_substring_counter;

  localparam logic [osc_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int NUM_PHASES     = 14;
  localparam int PHASE_REQS     = 95;
  localparam int HOLD_PHASE     = 5;
  localparam int HOLDOFF_CYCLES = 250;
  localparam int IDLE_LIMIT     = 3000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_REPORTS    = 20;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  class occurrence_predictor;
    logic [osc_pkg::CFG_W-1:0]      pat_lo;
    logic [osc_pkg::CFG_W-1:0]      pat_hi;
    logic [osc_pkg::LEN_W-1:0]      pat_len;
    logic [7:0]                     history [osc_pkg::WIN_DEPTH];
    int unsigned                    fill;
    logic [osc_pkg::COUNT_BITS-1:0] count;
    osc_pkg::out_rsp_t              expected_rsps [$];
    int                             errors;

    function new();
      pat_lo  = '0;
      pat_hi  = '0;
      pat_len = 1;
      errors  = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (history[k]) history[k] = '0;
      fill  = 0;
      count = '0;
    endfunction

    function void write_reg(logic [osc_pkg::CFG_IDX_W-1:0] idx,
                            logic [osc_pkg::CFG_W-1:0] data);
      case (idx)
        osc_pkg::CFG_PAT_LO:  pat_lo = data;
        osc_pkg::CFG_PAT_HI:  pat_hi = data;
        osc_pkg::CFG_PAT_LEN: pat_len = data[osc_pkg::LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] pattern_byte(int k);
      logic [osc_pkg::PAT_W-1:0] bits;
      bits = {pat_hi, pat_lo};
      return bits[8*k +: 8];
    endfunction

    function void note_request(osc_pkg::in_req_t r);
      osc_pkg::out_rsp_t exp_rsp;
      int                n;
      int                k;
      logic              hit;
      n = (pat_len == 0) ? 1 : int'(pat_len);
      if (n > osc_pkg::MAX_PATTERN) n = osc_pkg::MAX_PATTERN;
      hit = (fill >= n - 1) && (r.text_byte == pattern_byte(n - 1));
      for (k = 0; k < n - 1; k++) begin
        if (history[k] != pattern_byte(n - 2 - k)) hit = 1'b0;
      end
      if (hit && count != '1) count++;
      exp_rsp.match_end        = hit;
      exp_rsp.occurrence_count = count[osc_pkg::OCC_W-1:0];
      exp_rsp.result_last      = r.text_last;
      expected_rsps.push_back(exp_rsp);
      if (r.text_last) begin
        clear_text();
      end else begin
        for (k = osc_pkg::WIN_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
        history[0] = r.text_byte;
        if (fill < osc_pkg::WIN_DEPTH) fill++;
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(osc_pkg::out_rsp_t got);
      osc_pkg::out_rsp_t want;
      if (expected_rsps.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", got));
        return;
      end
      want = expected_rsps.pop_front();
      if (got.match_end !== want.match_end)
        report_mismatch($sformatf("match_end got %b want %b",
                                  got.match_end, want.match_end));
      if (got.occurrence_count !== want.occurrence_count)
        report_mismatch($sformatf("occurrence_count got %0d want %0d",
                                  got.occurrence_count, want.occurrence_count));
      if (got.result_last !== want.result_last)
        report_mismatch($sformatf("result_last got %b want %b",
                                  got.result_last, want.result_last));
    endtask

    function int pending();
      return expected_rsps.size();
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  osc_pkg::in_req_t              in_req_i    = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  osc_pkg::out_rsp_t             out_rsp_o;
  logic                          cfg_we_i    = 1'b0;
  logic [osc_pkg::CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [osc_pkg::CFG_W-1:0]     cfg_data_i  = '0;

  occurrence_predictor occ_pred = new();

  logic [7:0] pat_b [osc_pkg::MAX_PATTERN];
  logic [7:0] alph [2];
  logic [7:0] text_src [$];
  int         len_use      = 1;
  int         text_left    = 0;
  bit         holdoff_req  = 1'b0;
  int         holdoff_left = 0;
  int         stall_left   = 0;
  int         stall_tick   = 0;
  rx_mode_e   rx_mode      = RX_FREE;

  always #5 clk_i = ~clk_i;

  overlapping_substring_counter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // sampled mid-cycle: values here hold at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) occ_pred.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) occ_pred.check_result(out_rsp_o);
    end
  end

  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else if (holdoff_req) begin
      holdoff_req = 1'b0;
      holdoff_left = HOLDOFF_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        rx_mode    = rx_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 150);
      end
      stall_left--;
      stall_tick++;
      case (rx_mode)
        RX_FREE:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 99) < 30);
        RX_HEAVY: out_stall_i <= ($urandom_range(0, 99) < 75);
        default:  out_stall_i <= (stall_tick % 5 < 2);
      endcase
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_request(osc_pkg::in_req_t r);
    logic taken;
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic idle_sender(int n);
    in_valid_i <= 1'b0;
    in_req_i   <= osc_pkg::in_req_t'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (occ_pred.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [osc_pkg::CFG_IDX_W-1:0] idx,
                           logic [osc_pkg::CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    occ_pred.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // pattern comes from pat_b; upper bits of the length write are noise
  task automatic configure(logic [osc_pkg::LEN_W-1:0] len_field, bit poke_unused);
    logic [osc_pkg::CFG_W-1:0] lo;
    logic [osc_pkg::CFG_W-1:0] hi;
    logic [osc_pkg::CFG_W-1:0] len_word;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pat_b[k];
      hi[8*k +: 8] = pat_b[k+8];
    end
    len_word = {$urandom, $urandom};
    len_word[osc_pkg::LEN_W-1:0] = len_field;
    write_reg(osc_pkg::CFG_PAT_LEN, len_word);
    write_reg(osc_pkg::CFG_PAT_LO, lo);
    write_reg(osc_pkg::CFG_PAT_HI, hi);
    if (poke_unused) write_reg(CFG_IDX_UNUSED, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    len_use = (len_field == 0) ? 1 : int'(len_field);
    if (len_use > osc_pkg::MAX_PATTERN) len_use = osc_pkg::MAX_PATTERN;
  endtask

  // mostly pattern copies and alphabet runs, some partial copies and noise
  function automatic logic [7:0] next_text_byte();
    int pick;
    int cnt;
    if (text_src.size() == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        for (int k = 0; k < len_use; k++) text_src.push_back(pat_b[k]);
      end else if (pick < 8) begin
        cnt = $urandom_range(1, 3);
        repeat (cnt) text_src.push_back(alph[$urandom_range(0, 1)]);
      end else if (pick == 8) begin
        text_src.push_back(8'($urandom));
      end else begin
        cnt = $urandom_range(1, len_use);
        for (int k = 0; k < cnt; k++) text_src.push_back(pat_b[k]);
      end
    end
    return text_src.pop_front();
  endfunction

  function automatic osc_pkg::in_req_t next_request();
    osc_pkg::in_req_t r;
    if (text_left == 0)
      text_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 48);
    text_left--;
    r.text_byte = next_text_byte();
    r.text_last = (text_left == 0);
    return r;
  endfunction

  task automatic setup_phase(int p);
    int                        mode;
    logic [osc_pkg::LEN_W-1:0] len_field;
    mode    = $urandom_range(0, 2);
    alph[0] = 8'($urandom);
    alph[1] = (mode == 1) ? alph[0] : 8'($urandom);
    case (p)
      0:       len_field = osc_pkg::LEN_W'(1);
      1, 2:    len_field = osc_pkg::LEN_W'(osc_pkg::MAX_PATTERN);
      3:       len_field = '0;
      4:       len_field = osc_pkg::LEN_W'($urandom_range(osc_pkg::MAX_PATTERN + 1, 31));
      default: len_field = ($urandom_range(0, 9) < 7) ?
                           osc_pkg::LEN_W'($urandom_range(1, 5)) :
                           osc_pkg::LEN_W'($urandom_range(6, osc_pkg::MAX_PATTERN));
    endcase
    foreach (pat_b[k]) pat_b[k] = (mode == 2) ? 8'($urandom) : alph[$urandom_range(0, 1)];
    if (p == 1 || p == 2) begin
      alph[0] = (p == 1) ? 8'h00 : 8'hFF;
      alph[1] = alph[0];
      foreach (pat_b[k]) pat_b[k] = alph[0];
    end
    text_src.delete();
    configure(len_field, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int burst_left;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pattern: single zero byte
    send_request({8'h00, 1'b0});
    send_request({8'hFF, 1'b0});
    send_request({8'h00, 1'b1});
    wait_drained();

    // zero length acts as one; unused index ignored
    foreach (pat_b[k]) pat_b[k] = 8'h00;
    pat_b[0] = 8'hFF;
    configure(0, 1'b1);
    send_request({8'hFF, 1'b0});
    send_request({8'h7F, 1'b1});
    wait_drained();

    // overlapping hits
    pat_b[0] = 8'h61;
    pat_b[1] = 8'h62;
    pat_b[2] = 8'h61;
    configure(3, 1'b0);
    send_request({8'h61, 1'b0});
    send_request({8'h62, 1'b0});
    send_request({8'h61, 1'b0});
    send_request({8'h62, 1'b0});
    send_request({8'h61, 1'b1});
    wait_drained();

    // oversize length clamps; zero window must not count before it fills
    foreach (pat_b[k]) pat_b[k] = 8'h00;
    configure(31, 1'b0);
    repeat (osc_pkg::MAX_PATTERN - 1) send_request({8'h00, 1'b0});
    send_request({8'h00, 1'b1});

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      setup_phase(p);
      burst_left = 0;
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (p != HOLD_PHASE && p % 4 != 3 && burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          idle_sender($urandom_range(1, 10));
        end
        if (p == HOLD_PHASE && i == 3) holdoff_req = 1'b1;
        send_request(next_request());
        if (burst_left > 0) burst_left--;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (occ_pred.errors == 0 && occ_pred.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
